>>> rtl/core/sbcd_pkg.sv
// Shared types and constants for the sector block cache directory.
// No dependencies; imported by sbcd_epoch_ctrl, the directory unit and its testbench.
`default_nettype none
package sbcd_pkg;

  // Sector and tag widths fixed by the disc addressing.
  localparam int unsigned SECTOR_BITS = 32;
  localparam int unsigned TRACK_BITS  = 31;
  localparam int unsigned MODE_BITS   = 2;
  // Generation mark kept with each tag; zero is never a live generation.
  localparam int unsigned EPOCH_BITS  = 8;

  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = {EPOCH_BITS{1'b1}};
  localparam logic [EPOCH_BITS-1:0] EPOCH_DEAD  = '0;

  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_FILL       = 2'd1,
    OP_INVALIDATE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    CT_RUN,
    CT_CLEAR
  } ctl_state_t;

  // Control status from the generation controller to the datapath.
  typedef struct packed {
    logic                  busy;
    logic [EPOCH_BITS-1:0] epoch;
  } dir_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/sbcd_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module sbcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, otherwise read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/sbcd_epoch_ctrl.sv
// Generation controller: current tag generation and the clearing sweep.
// Depends on sbcd_pkg.
`default_nettype none
module sbcd_epoch_ctrl #(
  parameter int unsigned INDEX_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  inv_req,
  output sbcd_pkg::dir_ctl_t         ctl,
  output logic      [INDEX_BITS-1:0] clr_addr
);
  import sbcd_pkg::*;

  ctl_state_t            state, state_next;
  logic [EPOCH_BITS-1:0] epoch, epoch_next;
  logic [INDEX_BITS-1:0] clr_addr_next;

  // Hold state, generation and sweep address.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CT_CLEAR;
      epoch    <= EPOCH_FIRST;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      epoch    <= epoch_next;
      clr_addr <= clr_addr_next;
    end
  end

  // Advance the generation on invalidate; sweep the memory when it wraps.
  always_comb begin
    state_next    = state;
    epoch_next    = epoch;
    clr_addr_next = clr_addr;
    case (state)
      CT_RUN: begin
        if (inv_req) begin
          if (epoch == EPOCH_LAST) begin
            state_next    = CT_CLEAR;
            epoch_next    = EPOCH_FIRST;
            clr_addr_next = '0;
          end else begin
            epoch_next = epoch + EPOCH_BITS'(1);
          end
        end
      end
      CT_CLEAR: begin
        clr_addr_next = clr_addr + INDEX_BITS'(1);
        if (clr_addr == {INDEX_BITS{1'b1}}) begin
          state_next = CT_RUN;
        end
      end
      default: begin
        state_next = CT_CLEAR;
      end
    endcase
  end

  assign ctl.busy  = (state == CT_CLEAR);
  assign ctl.epoch = epoch;

endmodule
`default_nettype wire

>>> rtl/core/sector_block_cache_directory_unit.sv
// Sector block cache directory: a direct-mapped tag directory in one RAM.
// A command is taken when start is high and busy is low; it may follow the previous
// one in the next cycle, so the block takes one word per cycle while busy stays low. Its
// result passes the request stage and the result register onto status, entry_index and
// block_sector, marked by done for one cycle; the receiver cannot stall it, so it must
// take every result as it comes. Each tag entry carries a generation mark:
// invalidate-all only advances the generation, and entries of older generations read
// as invalid. After reset, and on every 255th invalidate when the mark wraps, busy is
// high while every tag RAM entry is swept, one per cycle; no command is taken then.
// Depends on sbcd_pkg, sbcd_ram and sbcd_epoch_ctrl.
`default_nettype none
module sector_block_cache_directory_unit #(
  parameter int unsigned INDEX_BITS = 10,
  parameter int unsigned BLOCK_BITS = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         operation,
  input  wire logic [sbcd_pkg::SECTOR_BITS-1:0]   sector,
  input  wire logic [sbcd_pkg::MODE_BITS-1:0]     read_mode,
  input  wire logic                               cfg_we,
  input  wire logic [sbcd_pkg::TRACK_BITS-1:0]    cfg_wdata,
  output logic                                    done,
  output logic [1:0]                              status,
  output logic      [INDEX_BITS-1:0]              entry_index,
  output logic      [sbcd_pkg::SECTOR_BITS-1:0]   block_sector
);
  import sbcd_pkg::*;

  localparam int unsigned DEPTH    = 1 << INDEX_BITS;
  localparam int unsigned TAG_BITS = SECTOR_BITS + MODE_BITS + EPOCH_BITS;
  localparam logic [SECTOR_BITS-1:0] BLOCK_MASK =
    SECTOR_BITS'((64'd1 << BLOCK_BITS) - 64'd1);

  dir_ctl_t              ctl;
  logic [INDEX_BITS-1:0] clr_addr;
  logic [TRACK_BITS-1:0] track_length;
  logic                  accept;
  logic [SECTOR_BITS-1:0] aligned;
  logic [SECTOR_BITS-1:0] hash_src;
  logic [INDEX_BITS-1:0] hash;
  logic                  in_range;

  // Request stage word.
  logic                   s1_valid;
  logic                   s1_check;
  logic [1:0]             s1_status;
  logic [INDEX_BITS-1:0]  s1_index;
  logic [SECTOR_BITS-1:0] s1_block;
  logic [MODE_BITS-1:0]   s1_mode;
  logic [EPOCH_BITS-1:0]  s1_epoch;
  logic                   s1_check_next;
  logic [1:0]             s1_status_next;
  logic [INDEX_BITS-1:0]  s1_index_next;
  logic [SECTOR_BITS-1:0] s1_block_next;

  // Tag RAM port.
  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_addr;
  logic [TAG_BITS-1:0]   ram_wdata;
  logic [TAG_BITS-1:0]   ram_rdata;
  logic                  hit;

  assign busy   = ctl.busy;
  assign accept = start && !ctl.busy;

  // Hold the track length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      track_length <= '0;
    end else if (cfg_we) begin
      track_length <= cfg_wdata;
    end
  end

  // Align for lookups; fills hash the sector as given.
  assign aligned  = sector & ~BLOCK_MASK;
  assign hash_src = (operation == OP_LOOKUP) ? aligned : sector;
  assign in_range = sector < {1'b0, track_length};

  // Fold the sector into index-wide slices, then mix in the mode.
  always_comb begin
    hash = '0;
    for (int unsigned p = 0; p < SECTOR_BITS; p += INDEX_BITS) begin
      hash = hash ^ INDEX_BITS'(hash_src >> p);
    end
    hash = hash ^ {{(INDEX_BITS-MODE_BITS){1'b0}}, read_mode};
  end

  sbcd_epoch_ctrl #(
    .INDEX_BITS(INDEX_BITS)
  ) u_epoch_ctrl (
    .clk      (clk),
    .rst      (rst),
    .inv_req  (accept && (operation == OP_INVALIDATE)),
    .ctl      (ctl),
    .clr_addr (clr_addr)
  );

  // Sweep writes dead tags; a fill writes its tag at once, a lookup reads.
  assign ram_we    = ctl.busy || (accept && (operation == OP_FILL));
  assign ram_addr  = ctl.busy ? clr_addr : hash;
  assign ram_wdata = ctl.busy ? {{(SECTOR_BITS+MODE_BITS){1'b0}}, EPOCH_DEAD}
                              : {sector, read_mode, ctl.epoch};

  sbcd_ram #(
    .WIDTH(TAG_BITS),
    .DEPTH(DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Decode the command into the stage word.
  always_comb begin
    s1_check_next  = 1'b0;
    s1_status_next = ST_HIT;
    s1_index_next  = '0;
    s1_block_next  = '0;
    case (op_t'(operation))
      OP_LOOKUP: begin
        if (in_range) begin
          s1_check_next = 1'b1;
          s1_index_next = hash;
          s1_block_next = aligned;
        end else begin
          s1_status_next = ST_RANGE;
        end
      end
      OP_FILL: begin
        s1_index_next = hash;
        s1_block_next = sector;
      end
      default: begin
        s1_status_next = ST_HIT;
      end
    endcase
  end

  // Hold the command while the tag is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_check  <= s1_check_next;
      s1_status <= s1_status_next;
      s1_index  <= s1_index_next;
      s1_block  <= s1_block_next;
      s1_mode   <= read_mode;
      s1_epoch  <= ctl.epoch;
    end
  end

  // Compare against the stored tag of the current generation.
  assign hit = (ram_rdata[EPOCH_BITS-1:0] == s1_epoch) &&
               (ram_rdata[EPOCH_BITS +: MODE_BITS] == s1_mode) &&
               (ram_rdata[EPOCH_BITS+MODE_BITS +: SECTOR_BITS] == s1_block);

  // Register the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      status       <= s1_check ? (hit ? ST_HIT : ST_MISS) : s1_status;
      entry_index  <= s1_index;
      block_sector <= s1_block;
    end
  end

  // The clearing sweep starts straight out of reset.
  a_sweep_after_reset: assert property (@(posedge clk) $past(rst) |-> busy)
    else $error("clearing sweep not running after reset");

  // Every accepted command yields a result through the request stage and the result register.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted command produced no result");

  // No result without a command accepted ahead of it through the request stage and result register.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without accepted command");

  // The live generation is never the dead mark.
  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    ctl.epoch != EPOCH_DEAD)
    else $error("generation mark hit the dead value");

endmodule
`default_nettype wire

>>> tb/sv/sector_block_cache_directory_unit_tb.sv
// Self-checking testbench for the sector block cache directory unit.
// Predicts each command word in a directory model of its own and compares every result.
// Depends on sbcd_pkg and sector_block_cache_directory_unit.
`default_nettype none
module sector_block_cache_directory_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbcd_pkg::*;

  localparam int unsigned IDX_W       = 10;
  localparam int unsigned BLK_W       = 4;
  localparam int unsigned ENTRIES     = 1 << IDX_W;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RECENT_MAX  = 48;
  localparam int unsigned GAP_PERCENT = 27;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [30:0] TRACK_MAX   = 31'h7FFF_FFFF;

  typedef struct packed {
    status_t           st;
    logic [IDX_W-1:0]  idx;
    logic [31:0]       blk;
  } outcome_t;

  typedef struct {
    logic [31:0] base;
    logic [1:0]  mode;
  } fill_tag_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [1:0]             operation;
  logic [31:0]            sector;
  logic [1:0]             read_mode;
  logic                   cfg_we;
  logic [30:0]            cfg_wdata;
  logic                   done;
  logic [1:0]             status;
  logic [IDX_W-1:0]       entry_index;
  logic [31:0]            block_sector;

  // Directory copy kept by the testbench
  logic [31:0]            tag_sector [ENTRIES];
  logic [1:0]             tag_mode [ENTRIES];
  bit                     entry_valid [ENTRIES];
  logic [30:0]            track_len;
  fill_tag_t              recent_fills [$];

  outcome_t               outcomes_due [$];
  int unsigned            bad_words;
  int unsigned            cycle_count;
  bit                     steady;

  sector_block_cache_directory_unit #(
    .INDEX_BITS(IDX_W),
    .BLOCK_BITS(BLK_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .sector(sector),
    .read_mode(read_mode),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .status(status),
    .entry_index(entry_index),
    .block_sector(block_sector)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // XOR fold of the 10-bit slices of the sector, then mix in the mode
  function automatic logic [IDX_W-1:0] fold_index(input logic [31:0] sec, input logic [1:0] md);
    return sec[9:0] ^ sec[19:10] ^ sec[29:20] ^ {8'b0, sec[31:30]} ^ {8'b0, md};
  endfunction

  // Apply one command word to the directory copy and return the result it gives
  function automatic outcome_t directory_outcome(input logic [1:0] op, input logic [31:0] sec,
                                                 input logic [1:0] md);
    outcome_t         r;
    logic [31:0]      blk;
    logic [IDX_W-1:0] idx;
    r = '{st: ST_HIT, idx: '0, blk: '0};
    case (op)
      OP_LOOKUP: begin
        if (sec >= {1'b0, track_len}) begin
          r.st = ST_RANGE;
        end else begin
          blk   = {sec[31:4], 4'b0};
          idx   = fold_index(blk, md);
          r.idx = idx;
          r.blk = blk;
          r.st  = (entry_valid[idx] && tag_sector[idx] == blk && tag_mode[idx] == md) ?
                  ST_HIT : ST_MISS;
        end
      end
      OP_FILL: begin
        idx                = fold_index(sec, md);
        tag_sector[idx]    = sec;
        tag_mode[idx]      = md;
        entry_valid[idx]   = 1'b1;
        r.idx              = idx;
        r.blk              = sec;
        recent_fills.push_back('{base: sec, mode: md});
        if (recent_fills.size() > RECENT_MAX) void'(recent_fills.pop_front());
      end
      OP_INVALIDATE: begin
        entry_valid = '{default: 1'b0};
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Send one command word, idling first at random unless steady, and hold until it is taken
  task automatic send_word(input logic [1:0] op, input logic [31:0] sec, input logic [1:0] md);
    if (!steady) begin
      while ($urandom_range(0, 99) < GAP_PERCENT) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    start     = 1'b1;
    operation = op;
    sector    = sec;
    read_mode = md;
    @(posedge clk);
    while (busy) @(posedge clk);
    outcomes_due.push_back(directory_outcome(op, sec, md));
  endtask

  // Drop start and hold until every pending result is back and the sweep is over
  task automatic drain_words();
    @(negedge clk);
    start = 1'b0;
    while (outcomes_due.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_track_length(input logic [30:0] value);
    drain_words();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    track_len = value;
  endtask

  // Hits, misses by tag, collisions, extremes, the unused code and invalidate
  task automatic test_directed();
    write_track_length(TRACK_MAX);
    send_word(OP_FILL, 32'h0, 2'd0);
    send_word(OP_LOOKUP, 32'h5, 2'd0);
    send_word(OP_FILL, 32'h1, 2'd0);
    send_word(OP_LOOKUP, 32'h0, 2'd1);
    send_word(OP_FILL, 32'h20, 2'd2);
    send_word(OP_LOOKUP, 32'h2F, 2'd2);
    // overwrite the same entry from another slice and mode
    send_word(OP_FILL, 32'h420, 2'd3);
    send_word(OP_LOOKUP, 32'h20, 2'd2);
    send_word(OP_LOOKUP, 32'h42F, 2'd3);
    // unaligned fill tag never matches an aligned lookup
    send_word(OP_FILL, 32'h35, 2'd1);
    send_word(OP_LOOKUP, 32'h1430, 2'd1);
    send_word(OP_FILL, 32'hFFFF_FFFF, 2'd3);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 2'd3);
    send_word(OP_FILL, 32'h7FFF_FFF0, 2'd0);
    send_word(OP_LOOKUP, 32'h7FFF_FFFE, 2'd0);
    send_word(OP_LOOKUP, 32'h7FFF_FFFF, 2'd0);
    send_word(OP_UNUSED, 32'hA5A5_A5A5, 2'd2);
    send_word(OP_UNUSED, 32'hFFFF_FFFF, 2'd3);
    send_word(OP_INVALIDATE, 32'h1234_5678, 2'd1);
    send_word(OP_LOOKUP, 32'h5, 2'd0);
    send_word(OP_FILL, 32'h0, 2'd0);
    send_word(OP_LOOKUP, 32'h3, 2'd0);
  endtask

  // Range check at empty, one-sector and mid-size tracks
  task automatic test_track_limits();
    write_track_length(31'd0);
    send_word(OP_LOOKUP, 32'h0, 2'd0);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 2'd3);
    send_word(OP_FILL, 32'h8000_0000, 2'd2);
    write_track_length(31'd1);
    send_word(OP_LOOKUP, 32'h0, 2'd0);
    send_word(OP_LOOKUP, 32'h1, 2'd0);
    write_track_length(31'h4000_0000);
    send_word(OP_FILL, 32'h3FFF_FFF0, 2'd1);
    send_word(OP_LOOKUP, 32'h3FFF_FFFF, 2'd1);
    send_word(OP_LOOKUP, 32'h4000_0000, 2'd1);
  endtask

  // Pick a sector from the whole space, a dense low range or the track boundary
  function automatic logic [31:0] pick_sector();
    case ($urandom_range(0, 2))
      0:       return $urandom;
      1:       return $urandom_range(0, 8191);
      default: return {1'b0, track_len} - $urandom_range(0, 64);
    endcase
  endfunction

  task automatic random_word();
    logic [1:0]  op;
    logic [31:0] sec;
    logic [1:0]  md;
    int unsigned pick;
    int unsigned r;
    pick = $urandom_range(0, 99);
    md   = 2'($urandom_range(0, 3));
    sec  = pick_sector();
    op   = OP_LOOKUP;
    if (pick < 35 && recent_fills.size() > 0) begin
      // revisit a recent block at any offset within it
      r   = $urandom_range(0, recent_fills.size() - 1);
      sec = {recent_fills[r].base[31:4], 4'($urandom_range(0, 15))};
      md  = recent_fills[r].mode;
    end else if (pick < 60) begin
      op = OP_FILL;
    end else if (pick < 80) begin
      op = OP_LOOKUP;
    end else if (pick < 88) begin
      sec = {1'b0, track_len} + $urandom_range(0, 2) - 1;
    end else if (pick < 94) begin
      op = OP_INVALIDATE;
    end else begin
      op = OP_UNUSED;
    end
    send_word(op, sec, md);
  endtask

  task automatic test_random_traffic();
    write_track_length(TRACK_MAX);
    repeat (170) random_word();
    // back-to-back words with no gaps at all
    write_track_length(31'd5000);
    steady = 1'b1;
    repeat (140) random_word();
    steady = 1'b0;
    write_track_length(31'($urandom_range(16, 32'h7FFF_FFFE)));
    repeat (140) random_word();
  endtask

  // Enough invalidates to wrap the generation mark and force a sweep
  task automatic test_generation_wrap();
    logic [31:0] prev_sec;
    logic [1:0]  prev_md;
    logic [31:0] sec;
    logic [1:0]  md;
    write_track_length(TRACK_MAX);
    for (int n = 0; n < 260; n++) begin
      send_word(OP_INVALIDATE, $urandom, 2'($urandom_range(0, 3)));
      if (n > 0) send_word(OP_LOOKUP, prev_sec, prev_md);
      sec = $urandom & 32'h7FFF_FFF0;
      md  = 2'($urandom_range(0, 3));
      send_word(OP_FILL, sec, md);
      if (n % 4 == 0) send_word(OP_LOOKUP, sec | 32'($urandom_range(0, 15)), md);
      prev_sec = sec;
      prev_md  = md;
    end
  endtask

  // Compare every result word with the oldest pending prediction
  always @(posedge clk) begin : check_word
    outcome_t want;
    if (!rst && done) begin
      if (outcomes_due.size() == 0) begin
        $display("%0t: result word with none pending: status %0d index %0d block %h",
                 $time, status, entry_index, block_sector);
        bad_words++;
      end else begin
        want = outcomes_due.pop_front();
        if (status !== want.st) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.st, status);
          bad_words++;
        end
        if (entry_index !== want.idx) begin
          $display("%0t: entry_index expected %0d, actual %0d", $time, want.idx, entry_index);
          bad_words++;
        end
        if (block_sector !== want.blk) begin
          $display("%0t: block_sector expected %h, actual %h", $time, want.blk, block_sector);
          bad_words++;
        end
      end
    end
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    operation   = '0;
    sector      = '0;
    read_mode   = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    track_len   = '0;
    steady      = 1'b0;
    bad_words   = 0;
    cycle_count = 0;
    entry_valid   = '{default: 1'b0};
    tag_sector    = '{default: '0};
    tag_mode      = '{default: '0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_track_limits();
    test_random_traffic();
    test_generation_wrap();
    drain_words();
    repeat (8) @(posedge clk);
    if (bad_words == 0 && outcomes_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
